/* design/tlm_pkg.sv */
// ----------------------------------------------------------------------------
// tlm_pkg
// Shared types and constants of the tilt leveler motor trial block.
// ----------------------------------------------------------------------------
package tlm_pkg;

  // Fixed field widths
  localparam int ANGLE_W   = 14;
  localparam int CAL_W     = 2;
  localparam int CALSUM_W  = 4;
  localparam int MAG_W     = 14;
  localparam int MOTORS    = 3;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  // Arithmetic constants
  localparam int WEIGHT_ONE    = 256;
  localparam int OFFSET_90_DEG = 1440;   // 90 degrees in 1/16 degree
  localparam logic [MAG_W-1:0] MAG_MAX = 14'h3FFF;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 14;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_TOLERANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_THRESHOLD  = 2'd3;

  // Motor trial verdict codes
  typedef logic [1:0] verdict_t;
  localparam verdict_t VERDICT_UNTESTED = 2'd0;
  localparam verdict_t VERDICT_HELPFUL  = 2'd1;
  localparam verdict_t VERDICT_HURTFUL  = 2'd2;

  typedef struct packed {
    logic [8:0]       smoothing_weight;
    logic [9:0]       change_tolerance;
    logic [MAG_W-1:0] level_threshold;
    logic [3:0]       calib_threshold;
  } cfg_t;

  typedef struct packed {
    logic [MOTORS-1:0]           motor_on;
    verdict_t [MOTORS-1:0]       verdict;
    logic                        calibrated;
    logic                        within_level;
  } status_t;

endpackage

/* design/tlm_mul.sv */
// ----------------------------------------------------------------------------
// tlm_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module tlm_mul #(
  parameter int OP_W = 23
) (
  input  logic                   clk_i,
  input  logic signed [OP_W-1:0] a_i,
  input  logic signed [OP_W-1:0] b_i,
  output logic signed [2*OP_W-1:0] prod_o
);

  logic signed [2*OP_W-1:0] prod_d, prod_q;

  assign prod_d = a_i * b_i;
  assign prod_o = prod_q;

  // product register, payload only
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

endmodule

/* design/tlm_isqrt.sv */
// ----------------------------------------------------------------------------
// tlm_isqrt
// Restoring integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module tlm_isqrt #(
  parameter int ROOT_W = 23
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [2*ROOT_W-1:0]   radicand_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [ROOT_W-1:0]     root_o
);

  localparam int CNT_W = $clog2(ROOT_W);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [ROOT_W:0]     rem_q, rem_d;
  logic [ROOT_W-1:0]   root_q, root_d;
  logic [2*ROOT_W-1:0] rad_q, rad_d;

  logic [ROOT_W+2:0]   rem_sh;
  logic [ROOT_W+2:0]   trial;
  logic [ROOT_W+2:0]   rem_sub;
  logic                ge;

  // one digit step: bring down two radicand bits, try (root << 2) | 1
  assign rem_sh  = {rem_q, rad_q[2*ROOT_W-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign ge      = (rem_sh >= trial);
  assign rem_sub = ge ? (rem_sh - trial) : rem_sh;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    root_d = root_q;
    rad_d  = rad_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(ROOT_W - 1);
      rem_d  = '0;
      root_d = '0;
      rad_d  = radicand_i;
    end else if (busy_q) begin
      rem_d  = rem_sub[ROOT_W:0];
      root_d = {root_q[ROOT_W-2:0], ge};
      rad_d  = {rad_q[2*ROOT_W-3:0], 2'b00};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
      rad_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= rad_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* design/tlm_policy.sv */
// ----------------------------------------------------------------------------
// tlm_policy
// Leveling decision: calibration latches, motor trials and verdicts.
// ----------------------------------------------------------------------------
module tlm_policy (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          strobe_i,
  input  logic [tlm_pkg::MAG_W-1:0]     mag_i,
  input  logic [tlm_pkg::CALSUM_W-1:0]  cal_sum_i,
  input  tlm_pkg::cfg_t                 cfg_i,
  output tlm_pkg::status_t              status_o
);

  logic                                cal_q, cal_d;
  logic                                init_q, init_d;
  tlm_pkg::verdict_t [tlm_pkg::MOTORS-1:0] ver_q, ver_d;
  logic [tlm_pkg::MOTORS-1:0]          en_q, en_d;
  logic [tlm_pkg::MAG_W-1:0]           prev_q, prev_d;

  tlm_pkg::verdict_t                   judgement;
  logic signed [15:0]                  diff;
  logic signed [15:0]                  tol;

  // change of magnitude against the previous sample
  assign diff = $signed({2'b00, prev_q}) - $signed({2'b00, mag_i});
  assign tol  = $signed({6'b0, cfg_i.change_tolerance});

  always_comb begin
    if (diff > tol) begin
      judgement = tlm_pkg::VERDICT_HELPFUL;
    end else if (diff < -tol) begin
      judgement = tlm_pkg::VERDICT_HURTFUL;
    end else begin
      judgement = tlm_pkg::VERDICT_UNTESTED;
    end
  end

  // next state of the leveling policy
  always_comb begin
    cal_d  = cal_q;
    init_d = init_q;
    ver_d  = ver_q;
    en_d   = en_q;
    prev_d = prev_q;
    if (strobe_i) begin
      prev_d = mag_i;
      if (mag_i >= cfg_i.level_threshold) begin
        if (!cal_q && (cal_sum_i >= cfg_i.calib_threshold)) begin
          cal_d = 1'b1;
        end
        if (cal_d && !init_q) begin
          init_d = 1'b1;
        end
        // try one motor at a time
        if (init_d && (ver_q[0] == tlm_pkg::VERDICT_UNTESTED)) begin
          en_d[0] = 1'b1;
          if (judgement != tlm_pkg::VERDICT_UNTESTED) begin
            ver_d[0] = judgement;
            en_d[0]  = 1'b0;
          end
        end else if ((ver_q[0] != tlm_pkg::VERDICT_UNTESTED) &&
                     (ver_q[1] == tlm_pkg::VERDICT_UNTESTED)) begin
          en_d[1] = 1'b1;
          if (judgement != tlm_pkg::VERDICT_UNTESTED) begin
            ver_d[1] = judgement;
            en_d[1]  = 1'b0;
          end
        end else if ((ver_q[1] != tlm_pkg::VERDICT_UNTESTED) &&
                     (ver_q[2] == tlm_pkg::VERDICT_UNTESTED)) begin
          en_d[2] = 1'b1;
          if (judgement != tlm_pkg::VERDICT_UNTESTED) begin
            ver_d[2] = judgement;
            en_d[2]  = 1'b0;
          end
        end
        // all judged: drive helpful motors, restart when no longer improving
        if ((ver_d[0] != tlm_pkg::VERDICT_UNTESTED) &&
            (ver_d[1] != tlm_pkg::VERDICT_UNTESTED) &&
            (ver_d[2] != tlm_pkg::VERDICT_UNTESTED)) begin
          for (int i = 0; i < tlm_pkg::MOTORS; i++) begin
            if (ver_d[i] == tlm_pkg::VERDICT_HELPFUL) begin
              en_d[i] = 1'b1;
            end
          end
          if (judgement != tlm_pkg::VERDICT_HELPFUL) begin
            ver_d = '0;
            en_d  = '0;
          end
        end
      end else begin
        en_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q  <= 1'b0;
      init_q <= 1'b0;
      ver_q  <= '0;
      en_q   <= '0;
      prev_q <= '0;
    end else begin
      cal_q  <= cal_d;
      init_q <= init_d;
      ver_q  <= ver_d;
      en_q   <= en_d;
      prev_q <= prev_d;
    end
  end

  assign status_o.motor_on     = en_q;
  assign status_o.verdict      = ver_q;
  assign status_o.calibrated   = cal_q;
  assign status_o.within_level = (prev_q < cfg_i.level_threshold);

  // below the threshold every motor stops
  a_stop_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_i && (mag_i < cfg_i.level_threshold)) |=> (en_q == '0))
    else $error("motors left on below level threshold");

  // during the trial phase at most one motor runs
  a_one_trial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((ver_q[0] == tlm_pkg::VERDICT_UNTESTED) || (ver_q[1] == tlm_pkg::VERDICT_UNTESTED) ||
     (ver_q[2] == tlm_pkg::VERDICT_UNTESTED)) |-> $onehot0(en_q))
    else $error("more than one motor on during trials");

  // no verdict code beyond hurtful is ever stored
  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ver_q[0] != 2'd3) && (ver_q[1] != 2'd3) && (ver_q[2] != 2'd3))
    else $error("invalid verdict stored");

endmodule

/* design/tilt_leveler_motor_trial_top.sv */
// ----------------------------------------------------------------------------
// tilt_leveler_motor_trial_top
// Tilt smoothing, magnitude and motor trial leveling over one shared multiplier.
// ----------------------------------------------------------------------------
// One orientation sample at a time: a new sample is taken only after the
// previous one has gone all the way back to the idle state. Six multiplies on
// the one shared multiplier (smoothing of both angles, then both squares) come
// first, and then the square root unit produces one root bit per cycle over
// SMOOTH_FRAC_BITS + 15 bits. s_axis_tready_o is high only while no sample is
// in work; the result sits in an output register, and a sample finishing while
// the previous result is still not taken waits for it. Configuration writes
// take effect at once and are meant to be made while the block is idle.
module tilt_leveler_motor_trial_top #(
  parameter int SMOOTH_FRAC_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [tlm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tlm_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // sample stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // orient_y[13:0], orient_z[27:14], cal_sys[29:28], cal_gyro[31:30],
  // cal_accel[33:32], cal_mag[35:34], zero[39:36]
  input  logic [tlm_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // result stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // motor_on[2:0], tilt_magnitude[16:3], verdict_one[18:17],
  // verdict_two[20:19], verdict_three[22:21], is_calibrated[23],
  // within_level[24], zero[31:25]
  output logic [tlm_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o
);

  localparam int F      = SMOOTH_FRAC_BITS;
  localparam int SW     = tlm_pkg::ANGLE_W + F;   // smoothed angle width
  localparam int MW     = SW + 1;                 // multiplier operand width
  localparam int PW     = 2 * MW;                 // product width
  localparam int RW     = MW;                     // root width
  localparam logic signed [MW-1:0] OFFSET_Q = MW'(tlm_pkg::OFFSET_90_DEG) <<< F;

  typedef enum logic [3:0] {
    ST_IDLE, ST_YW, ST_YS, ST_YA, ST_ZW, ST_ZS, ST_ZA,
    ST_SQY, ST_SQZ, ST_SUM, ST_ROOT, ST_JUDGE, ST_OUT
  } state_e;

  state_e                          state_q, state_d;
  tlm_pkg::cfg_t                   cfg_q, cfg_d;
  logic signed [tlm_pkg::ANGLE_W-1:0] y_q, y_d, z_q, z_d;
  logic [tlm_pkg::CALSUM_W-1:0]    cal_sum_q, cal_sum_d;
  logic [8:0]                      wc_q, wc_d;
  logic signed [SW-1:0]            sy_q, sy_d, sz_q, sz_d;
  logic signed [PW-1:0]            acc_q, acc_d;
  logic [tlm_pkg::MAG_W-1:0]       mag_q, mag_d;
  logic                            out_valid_q, out_valid_d;
  logic [tlm_pkg::OUT_DATA_W-1:0]  out_data_q, out_data_d;

  logic signed [MW-1:0]            mul_a, mul_b;
  logic signed [PW-1:0]            prod;
  logic signed [MW-1:0]            sy_ext, zo, ay, az;
  logic signed [MW-1:0]            w_op, wrem_op;
  logic signed [PW-1:0]            sum;
  logic signed [PW-1:0]            sum_sh;
  logic                            root_start, root_busy, root_done;
  logic [RW-1:0]                   root;
  logic [RW-F-1:0]                 root_hi;
  logic                            pol_strobe;
  tlm_pkg::status_t                status;
  logic [8:0]                      w_raw;

  // operand preparation
  assign w_raw   = cfg_q.smoothing_weight;
  assign w_op    = $signed({{(MW-9){1'b0}}, wc_q});
  assign wrem_op = $signed({{(MW-9){1'b0}}, 9'(10'd256 - {1'b0, wc_q})});
  assign sy_ext  = MW'(sy_q);
  assign zo      = MW'(sz_q) + OFFSET_Q;
  assign ay      = sy_ext[MW-1] ? -sy_ext : sy_ext;
  assign az      = zo[MW-1] ? -zo : zo;
  assign sum     = acc_q + prod;
  assign sum_sh  = sum >>> 8;
  assign root_hi = root[RW-1:F];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_YW: begin
        mul_a = MW'(y_q);
        mul_b = w_op;
      end
      ST_YS: begin
        mul_a = sy_ext;
        mul_b = wrem_op;
      end
      ST_ZW: begin
        mul_a = MW'(z_q);
        mul_b = w_op;
      end
      ST_ZS: begin
        mul_a = MW'(sz_q);
        mul_b = wrem_op;
      end
      ST_SQY: begin
        mul_a = ay;
        mul_b = ay;
      end
      ST_SQZ: begin
        mul_a = az;
        mul_b = az;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  tlm_mul #(
    .OP_W (MW)
  ) u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  tlm_isqrt #(
    .ROOT_W (RW)
  ) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i ($unsigned(sum)),
    .busy_o     (root_busy),
    .done_o     (root_done),
    .root_o     (root)
  );

  tlm_policy u_policy (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .strobe_i  (pol_strobe),
    .mag_i     (mag_q),
    .cal_sum_i (cal_sum_q),
    .cfg_i     (cfg_q),
    .status_o  (status)
  );

  assign root_start      = (state_q == ST_SUM);
  assign pol_strobe      = (state_q == ST_JUDGE) && !out_valid_q;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // sequencer and datapath registers
  always_comb begin
    state_d     = state_q;
    cfg_d       = cfg_q;
    y_d         = y_q;
    z_d         = z_q;
    cal_sum_d   = cal_sum_q;
    wc_d        = wc_q;
    sy_d        = sy_q;
    sz_d        = sz_q;
    acc_d       = acc_q;
    mag_d       = mag_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    // configuration writes
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tlm_pkg::CFG_SMOOTHING_WEIGHT: cfg_d.smoothing_weight = cfg_wdata_i[8:0];
        tlm_pkg::CFG_CHANGE_TOLERANCE: cfg_d.change_tolerance = cfg_wdata_i[9:0];
        tlm_pkg::CFG_LEVEL_THRESHOLD:  cfg_d.level_threshold  = cfg_wdata_i;
        tlm_pkg::CFG_CALIB_THRESHOLD:  cfg_d.calib_threshold  = cfg_wdata_i[3:0];
      endcase
    end

    // result transaction taken
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          y_d       = $signed(s_axis_tdata_i[13:0]);
          z_d       = $signed(s_axis_tdata_i[27:14]);
          cal_sum_d = {2'b00, s_axis_tdata_i[29:28]} + {2'b00, s_axis_tdata_i[31:30]} +
                      {2'b00, s_axis_tdata_i[33:32]} + {2'b00, s_axis_tdata_i[35:34]};
          wc_d      = (w_raw > 9'd256) ? 9'd256 : w_raw;
          state_d   = ST_YW;
        end
      end
      ST_YW: state_d = ST_YS;
      ST_YS: begin
        acc_d   = (prod <<< F) + PW'(128);
        state_d = ST_YA;
      end
      ST_YA: begin
        sy_d    = $signed(sum_sh[SW-1:0]);
        state_d = ST_ZW;
      end
      ST_ZW: state_d = ST_ZS;
      ST_ZS: begin
        acc_d   = (prod <<< F) + PW'(128);
        state_d = ST_ZA;
      end
      ST_ZA: begin
        sz_d    = $signed(sum_sh[SW-1:0]);
        state_d = ST_SQY;
      end
      ST_SQY: state_d = ST_SQZ;
      ST_SQZ: begin
        acc_d   = prod;
        state_d = ST_SUM;
      end
      ST_SUM: state_d = ST_ROOT;
      ST_ROOT: begin
        if (root_done) begin
          mag_d   = root_hi[tlm_pkg::MAG_W] ? tlm_pkg::MAG_MAX : root_hi[tlm_pkg::MAG_W-1:0];
          state_d = ST_JUDGE;
        end
      end
      ST_JUDGE: begin
        if (!out_valid_q) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        out_data_d  = {7'b0, status.within_level, status.calibrated,
                       status.verdict[2], status.verdict[1], status.verdict[0],
                       mag_q, status.motor_on};
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q                <= ST_IDLE;
      cfg_q.smoothing_weight <= 9'd230;
      cfg_q.change_tolerance <= 10'd16;
      cfg_q.level_threshold  <= 14'd80;
      cfg_q.calib_threshold  <= 4'd8;
      y_q                    <= '0;
      z_q                    <= '0;
      cal_sum_q              <= '0;
      wc_q                   <= '0;
      sy_q                   <= '0;
      sz_q                   <= '0;
      acc_q                  <= '0;
      mag_q                  <= '0;
      out_valid_q            <= 1'b0;
      out_data_q             <= '0;
    end else begin
      state_q     <= state_d;
      cfg_q       <= cfg_d;
      y_q         <= y_d;
      z_q         <= z_d;
      cal_sum_q   <= cal_sum_d;
      wc_q        <= wc_d;
      sy_q        <= sy_d;
      sz_q        <= sz_d;
      acc_q       <= acc_d;
      mag_q       <= mag_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  // a new result is only written into an empty output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> !out_valid_q)
    else $error("output register overwritten");

  // the root unit runs only while the sequencer waits for it
  a_root_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_busy |-> (state_q == ST_ROOT))
    else $error("square root busy outside root phase");

  // the policy is updated once per sample, after the root finishes and the output register is empty
  a_strobe_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pol_strobe |=> (state_q == ST_OUT))
    else $error("policy update without result");

endmodule

/* bench/tlm_level_check.sv */
// ----------------------------------------------------------------------------
// tlm_level_check
// Prediction and result comparison for the tilt leveler motor trial block.
// ----------------------------------------------------------------------------
// Watches the register write port and both stream channels. Every accepted
// sample goes through a local copy of the smoothing filters, the tilt
// magnitude and the motor trial sequencer. The result that this yields is
// queued. Every accepted result transaction is compared field by field with
// the oldest queued result. The failure count and the number of results
// still owed are handed back to the testbench top.
module tlm_level_check #(
  parameter int SMOOTH_FRAC_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tlm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tlm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  input  logic [tlm_pkg::IN_DATA_W-1:0]  s_tdata_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  input  logic [tlm_pkg::OUT_DATA_W-1:0] m_tdata_i,
  output int                             mismatches_o,
  output int                             pending_o,
  output int                             checked_o,
  output int                             driven_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FILT_W = tlm_pkg::ANGLE_W + SMOOTH_FRAC_BITS;

  // One sample, first field in the lowest bits
  typedef struct packed {
    logic [tlm_pkg::IN_DATA_W-37:0]      pad;
    logic [tlm_pkg::CAL_W-1:0]           cal_mag;
    logic [tlm_pkg::CAL_W-1:0]           cal_accel;
    logic [tlm_pkg::CAL_W-1:0]           cal_gyro;
    logic [tlm_pkg::CAL_W-1:0]           cal_sys;
    logic signed [tlm_pkg::ANGLE_W-1:0]  orient_z;
    logic signed [tlm_pkg::ANGLE_W-1:0]  orient_y;
  } sample_t;

  // One result, first field in the lowest bits
  typedef struct packed {
    logic                       within_level;
    logic                       calibrated;
    tlm_pkg::verdict_t          verdict_three;
    tlm_pkg::verdict_t          verdict_two;
    tlm_pkg::verdict_t          verdict_one;
    logic [tlm_pkg::MAG_W-1:0]  magnitude;
    logic [tlm_pkg::MOTORS-1:0] motor_on;
  } level_result_t;

  localparam int RES_W = $bits(level_result_t);

  // Register copies
  logic [8:0]                weight_q;
  logic [9:0]                tolerance_q;
  logic [tlm_pkg::MAG_W-1:0] level_thr_q;
  logic [3:0]                calib_thr_q;

  // Block state copy
  logic signed [FILT_W-1:0]   filt_y;
  logic signed [FILT_W-1:0]   filt_z;
  logic [tlm_pkg::MAG_W-1:0]  last_mag;
  logic                       calibrated;
  logic                       initialized;
  tlm_pkg::verdict_t          verdicts [tlm_pkg::MOTORS];
  logic [tlm_pkg::MOTORS-1:0] enables;

  level_result_t expected_q [$];

  // Exponential smoothing; the weight is in 1/256, so the division is a shift by 8
  function automatic logic signed [FILT_W-1:0] smooth(
    input logic signed [FILT_W-1:0] s,
    input logic signed [tlm_pkg::ANGLE_W-1:0] x);
    longint w;
    longint acc;
    w = (weight_q > tlm_pkg::WEIGHT_ONE) ? longint'(tlm_pkg::WEIGHT_ONE)
                                         : longint'(weight_q);
    acc = w * (longint'(x) <<< SMOOTH_FRAC_BITS) +
          (tlm_pkg::WEIGHT_ONE - w) * longint'(s) + 128;
    return FILT_W'(acc >>> 8);
  endfunction

  // Floor square root, one bit at a time from the top
  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  // Distance from level: y and z + 90 degrees, back to 1/16 degree, saturated
  function automatic logic [tlm_pkg::MAG_W-1:0] tilt_of(input logic signed [FILT_W-1:0] sy,
                                                        input logic signed [FILT_W-1:0] sz);
    longint      ay;
    longint      az;
    logic [63:0] root;
    ay = longint'(sy);
    az = longint'(sz) + (longint'(tlm_pkg::OFFSET_90_DEG) <<< SMOOTH_FRAC_BITS);
    if (ay < 0) ay = -ay;
    if (az < 0) az = -az;
    root = floor_sqrt(64'(ay * ay + az * az)) >> SMOOTH_FRAC_BITS;
    if (root > 64'(tlm_pkg::MAG_MAX)) return tlm_pkg::MAG_MAX;
    return root[tlm_pkg::MAG_W-1:0];
  endfunction

  // Drop in magnitude beyond the tolerance helps, a rise beyond it hurts
  function automatic tlm_pkg::verdict_t judge(input logic [tlm_pkg::MAG_W-1:0] cur);
    int d;
    d = int'(last_mag) - int'(cur);
    if (d > int'(tolerance_q)) return tlm_pkg::VERDICT_HELPFUL;
    if (d < -int'(tolerance_q)) return tlm_pkg::VERDICT_HURTFUL;
    return tlm_pkg::VERDICT_UNTESTED;
  endfunction

  task automatic try_motor(input int m, input logic [tlm_pkg::MAG_W-1:0] cur);
    tlm_pkg::verdict_t v;
    enables[m] = 1'b1;
    v = judge(cur);
    if (v != tlm_pkg::VERDICT_UNTESTED) begin
      verdicts[m] = v;
      enables[m] = 1'b0;
    end
  endtask

  task automatic predict_level(input logic [tlm_pkg::IN_DATA_W-1:0] raw);
    sample_t                      smp;
    logic [tlm_pkg::CALSUM_W-1:0] cal_sum;
    logic [tlm_pkg::MAG_W-1:0]    mag;
    level_result_t                res;
    smp = sample_t'(raw);
    cal_sum = tlm_pkg::CALSUM_W'(smp.cal_sys) + tlm_pkg::CALSUM_W'(smp.cal_gyro) +
              tlm_pkg::CALSUM_W'(smp.cal_accel) + tlm_pkg::CALSUM_W'(smp.cal_mag);
    filt_y = smooth(filt_y, smp.orient_y);
    filt_z = smooth(filt_z, smp.orient_z);
    mag = tilt_of(filt_y, filt_z);

    if (mag >= level_thr_q) begin
      if (!calibrated && cal_sum >= calib_thr_q) calibrated = 1'b1;
      if (calibrated && !initialized) initialized = 1'b1;

      // one motor on trial at a time
      if (initialized && verdicts[0] == tlm_pkg::VERDICT_UNTESTED) try_motor(0, mag);
      else if (verdicts[0] != tlm_pkg::VERDICT_UNTESTED &&
               verdicts[1] == tlm_pkg::VERDICT_UNTESTED)
        try_motor(1, mag);
      else if (verdicts[1] != tlm_pkg::VERDICT_UNTESTED &&
               verdicts[2] == tlm_pkg::VERDICT_UNTESTED)
        try_motor(2, mag);

      // all judged: drive helpful motors until the tilt stops improving
      if (verdicts[0] != tlm_pkg::VERDICT_UNTESTED &&
          verdicts[1] != tlm_pkg::VERDICT_UNTESTED &&
          verdicts[2] != tlm_pkg::VERDICT_UNTESTED) begin
        for (int m = 0; m < tlm_pkg::MOTORS; m++)
          if (verdicts[m] == tlm_pkg::VERDICT_HELPFUL) enables[m] = 1'b1;
        if (judge(mag) != tlm_pkg::VERDICT_HELPFUL) begin
          for (int m = 0; m < tlm_pkg::MOTORS; m++) verdicts[m] = tlm_pkg::VERDICT_UNTESTED;
          enables = '0;
        end
      end
    end else begin
      enables = '0;
    end
    last_mag = mag;

    res.motor_on      = enables;
    res.magnitude     = mag;
    res.verdict_one   = verdicts[0];
    res.verdict_two   = verdicts[1];
    res.verdict_three = verdicts[2];
    res.calibrated    = calibrated;
    res.within_level  = (mag < level_thr_q);
    expected_q.push_back(res);
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches_o++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  task automatic check_result(input logic [tlm_pkg::OUT_DATA_W-1:0] raw);
    level_result_t got;
    level_result_t want;
    got = level_result_t'(raw[RES_W-1:0]);
    if (expected_q.size() == 0) begin
      mismatches_o++;
      $display("%0t: result with no sample outstanding, expected none, actual 0x%h",
               $time, raw);
    end else begin
      want = expected_q.pop_front();
      check_field("motor_on", want.motor_on, got.motor_on);
      check_field("tilt_magnitude", want.magnitude, got.magnitude);
      check_field("verdict_one", want.verdict_one, got.verdict_one);
      check_field("verdict_two", want.verdict_two, got.verdict_two);
      check_field("verdict_three", want.verdict_three, got.verdict_three);
      check_field("is_calibrated", want.calibrated, got.calibrated);
      check_field("within_level", want.within_level, got.within_level);
      check_field("padding", 0, raw[tlm_pkg::OUT_DATA_W-1:RES_W]);
      checked_o++;
      if (got.motor_on != '0) driven_o++;
    end
  endtask

  // Register writes, result checks and sample predictions, at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q     = 9'd230;
      tolerance_q  = 10'd16;
      level_thr_q  = 14'd80;
      calib_thr_q  = 4'd8;
      filt_y       = '0;
      filt_z       = '0;
      last_mag     = '0;
      calibrated   = 1'b0;
      initialized  = 1'b0;
      for (int m = 0; m < tlm_pkg::MOTORS; m++) verdicts[m] = tlm_pkg::VERDICT_UNTESTED;
      enables      = '0;
      expected_q.delete();
      mismatches_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      driven_o     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tlm_pkg::CFG_SMOOTHING_WEIGHT: weight_q    = cfg_wdata_i[8:0];
          tlm_pkg::CFG_CHANGE_TOLERANCE: tolerance_q = cfg_wdata_i[9:0];
          tlm_pkg::CFG_LEVEL_THRESHOLD:  level_thr_q = cfg_wdata_i[tlm_pkg::MAG_W-1:0];
          tlm_pkg::CFG_CALIB_THRESHOLD:  calib_thr_q = cfg_wdata_i[3:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) check_result(m_tdata_i);
      if (s_tvalid_i && s_tready_i) predict_level(s_tdata_i);
      pending_o = expected_q.size();
    end
  end

endmodule

/* bench/tb_tilt_leveler_motor_trial_top.sv */
// ----------------------------------------------------------------------------
// tb_tilt_leveler_motor_trial_top
// Stimulus and verdict for the tilt leveler motor trial block.
// ----------------------------------------------------------------------------
// Drives orientation samples into the block under several register settings:
// a short directed part with extreme angles and calibration levels, then
// random bursts that drift toward level, drift away, jitter or jump, so that
// the motor trials run through all their steps. Both stream sides stall at
// random. The checker beside the block predicts and compares every result.
module tb_tilt_leveler_motor_trial_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC        = 8;
  localparam int ANGLE_LIMIT = 5760;
  localparam int LEVEL_Z     = -tlm_pkg::OFFSET_90_DEG;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRE_ITEMS   = 4;
  localparam int DIR_ITEMS   = 20;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [tlm_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [tlm_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [tlm_pkg::IN_DATA_W-1:0]  s_tdata;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [tlm_pkg::OUT_DATA_W-1:0] m_tdata;

  int mismatches;
  int pending;
  int checked;
  int driven;
  int cycle_count = 0;
  int items_sent = 0;
  int send_fast_left = 0;
  int walk_y = 0;
  int walk_z = LEVEL_Z;

  // Directed angles: level, extremes, a slow return to level, small values
  int dir_y [DIR_ITEMS] = '{0, 5760, 5760, 5760, -5760, -5760, 5760, 0, 0, 0,
                            0, 0, 0, 0, 0, 100, 2000, 4000, -1, 1};
  int dir_z [DIR_ITEMS] = '{-1440, 5760, 5760, 5760, -5760, 5760, -5760, 0, 0, 0,
                            -1000, -1200, -1300, -1400, -1440, -1440, 0, 2000, -1, 1};

  tilt_leveler_motor_trial_top #(
    .SMOOTH_FRAC_BITS(FRAC)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  tlm_level_check #(
    .SMOOTH_FRAC_BITS(FRAC)
  ) u_level_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .driven_o     (driven)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles", cycle_count);
    $display("Verification failed");
    $finish;
  end

  // cal byte is {cal_mag, cal_accel, cal_gyro, cal_sys}
  function automatic logic [tlm_pkg::IN_DATA_W-1:0] pack_sample(input int y, input int z,
                                                                input logic [7:0] cal);
    return {{(tlm_pkg::IN_DATA_W - 36){1'b0}}, cal,
            z[tlm_pkg::ANGLE_W-1:0], y[tlm_pkg::ANGLE_W-1:0]};
  endfunction

  function automatic int clamp_angle(input int v);
    if (v > ANGLE_LIMIT) return ANGLE_LIMIT;
    if (v < -ANGLE_LIMIT) return -ANGLE_LIMIT;
    return v;
  endfunction

  // Move an angle toward its level value without overshoot, or away from it
  function automatic int drift(input int v, input int target, input int step,
                               input bit toward);
    int dir;
    dir = (v > target) ? 1 : (v < target) ? -1 : (($urandom_range(0, 1) == 1) ? 1 : -1);
    if (toward) begin
      if (step > (v - target) * dir) step = (v - target) * dir;
      return v - dir * step;
    end
    return clamp_angle(v + dir * step);
  endfunction

  // Receiver: random stall before each result, with stretches of none
  initial begin
    int stall;
    int fast_left;
    stall = 0;
    fast_left = 0;
    m_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
      end
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (fast_left > 0) begin
          fast_left--;
          stall = 0;
        end else if ($urandom_range(0, 15) == 0) begin
          fast_left = $urandom_range(10, 40);
          stall = 0;
        end else begin
          stall = $urandom_range(0, 8);
        end
      end
    end
  end

  // One sample transaction after a random gap
  task automatic send_sample(input logic [tlm_pkg::IN_DATA_W-1:0] word);
    int gap;
    if (send_fast_left > 0) begin
      gap = 0;
      send_fast_left--;
    end else begin
      gap = $urandom_range(0, 8);
    end
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Hold off until every result is back; the block is idle then
  task automatic wait_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_config(input int weight, input int tol, input int level_thr,
                            input int calib_thr);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= tlm_pkg::CFG_SMOOTHING_WEIGHT;
    cfg_wdata <= tlm_pkg::CFG_DATA_W'(weight);
    @(negedge clk);
    cfg_idx   <= tlm_pkg::CFG_CHANGE_TOLERANCE;
    cfg_wdata <= tlm_pkg::CFG_DATA_W'(tol);
    @(negedge clk);
    cfg_idx   <= tlm_pkg::CFG_LEVEL_THRESHOLD;
    cfg_wdata <= tlm_pkg::CFG_DATA_W'(level_thr);
    @(negedge clk);
    cfg_idx   <= tlm_pkg::CFG_CALIB_THRESHOLD;
    cfg_wdata <= tlm_pkg::CFG_DATA_W'(calib_thr);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random bursts: mostly drifts toward or away from level, some jitter and jumps
  task automatic random_items(input int count);
    int sent;
    int burst_left;
    int mode;
    int step_max;
    int span;
    int y;
    int z;
    logic [7:0] cal;
    sent = 0;
    burst_left = 0;
    mode = 0;
    step_max = 0;
    while (sent < count) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(4, 24);
        mode = $urandom_range(0, 9);
        case ($urandom_range(0, 4))
          0:       step_max = 2;
          1:       step_max = 8;
          2:       step_max = 40;
          3:       step_max = 200;
          default: step_max = 800;
        endcase
        if ($urandom_range(0, 5) == 0) send_fast_left = burst_left;
      end
      if (mode <= 3) begin
        walk_y = drift(walk_y, 0, $urandom_range(0, step_max), 1'b1);
        walk_z = drift(walk_z, LEVEL_Z, $urandom_range(0, step_max), 1'b1);
      end else if (mode <= 5) begin
        walk_y = drift(walk_y, 0, $urandom_range(0, step_max), 1'b0);
        walk_z = drift(walk_z, LEVEL_Z, $urandom_range(0, step_max), 1'b0);
      end else if (mode <= 8) begin
        span = (mode == 8) ? step_max : step_max / 4;
        walk_y = clamp_angle(walk_y + int'($urandom_range(0, 2 * span)) - span);
        walk_z = clamp_angle(walk_z + int'($urandom_range(0, 2 * span)) - span);
      end
      if (mode == 9) begin
        // isolated jumps anywhere in range
        y = int'($urandom_range(0, 2 * ANGLE_LIMIT)) - ANGLE_LIMIT;
        z = int'($urandom_range(0, 2 * ANGLE_LIMIT)) - ANGLE_LIMIT;
      end else begin
        y = walk_y;
        z = walk_z;
      end
      cal = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
      send_sample(pack_sample(y, z, cal));
      burst_left--;
      sent++;
    end
  endtask

  // Main sequence
  initial begin
    logic [7:0] cal;
    int count;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = tlm_pkg::CFG_SMOOTHING_WEIGHT;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Calibration threshold out of reach: large tilt must not start a trial
    set_config(230, 16, 80, 15);
    send_sample(pack_sample(5760, 5760, 8'hFF));
    send_sample(pack_sample(-5760, 5760, 8'hFF));
    send_sample(pack_sample(5760, -5760, 8'hFF));
    send_sample(pack_sample(-5760, -5760, 8'hFF));
    wait_results();

    // Directed angles at the default settings; sums 0 and 6 first, then calibrated
    set_config(230, 16, 80, 8);
    for (int k = 0; k < DIR_ITEMS; k++) begin
      cal = (k == 0) ? 8'h00 : (k == 1) ? 8'b00_11_10_01 : (k[0] ? 8'hFF : 8'hBE);
      send_sample(pack_sample(dir_y[k], dir_z[k], cal));
    end
    wait_results();

    // Random phases, register extremes among them
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_config(230, 16, 80, 8);
        1: set_config(256, 0, 0, 0);
        2: set_config(511, 1023, 16383, 12);
        3: set_config(0, 16, 80, 15);
        4: set_config(128, 4, 200, 4);
        5: set_config(200, 40, 40, 12);
        6: set_config(64, 100, 500, 0);
        default: set_config(255, 8, 80, 8);
      endcase
      count = (p == 2 || p == 3) ? 60 : 220;
      random_items(count);
      wait_results();
    end

    repeat (FRAC + 40) @(negedge clk);
    $display("Run covered %0d samples over 10 register settings, directed and random.",
             items_sent);
    $display("%0d results compared, %0d of them with at least one motor driven.",
             checked, driven);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/tlm_pkg.sv
design/tlm_mul.sv
design/tlm_isqrt.sv
design/tlm_policy.sv
design/tilt_leveler_motor_trial_top.sv
bench/tlm_level_check.sv
bench/tb_tilt_leveler_motor_trial_top.sv
